// ----- rtl/aitc_pkg.sv -----
// Shared types, character codes and group checks for the address text classifier.
`default_nettype none
package aitc_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    localparam logic [9:0] V4_GROUP_MAX = 10'd255;
    localparam logic [2:0] LEN_MAX      = 3'd7;
    localparam logic [2:0] DOT_MAX      = 3'd7;
    localparam logic [3:0] COLON_MAX    = 4'd15;
    localparam logic [2:0] V4_DOTS      = 3'd3;
    localparam logic [3:0] V6_COLONS    = 4'd7;
    localparam logic [2:0] V4_LEN_MAX   = 3'd3;
    localparam logic [2:0] V6_LEN_MAX   = 3'd4;

    typedef enum logic [1:0] {
        ACLS_NEITHER = 2'd0,
        ACLS_IPV4    = 2'd1,
        ACLS_IPV6    = 2'd2
    } t_addr_class;

    // One classification request on its way from the scanner to the output.
    typedef struct packed {
        logic        valid;
        t_addr_class address_class;
    } t_req;

    function automatic logic is_dec(input logic [7:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

    function automatic logic is_hex(input logic [7:0] ch);
        return is_dec(ch) || ((ch >= CH_LA) && (ch <= CH_LF))
            || ((ch >= CH_UA) && (ch <= CH_UF));
    endfunction

    function automatic logic v4_group_ok(input logic [2:0] len, input logic [9:0] val,
                                         input logic lz);
        logic ok;
        ok = (len != 3'd0) && (len <= V4_LEN_MAX) && (val <= V4_GROUP_MAX);
        if (lz && (len >= 3'd2)) begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic v6_group_ok(input logic [2:0] len);
        return (len != 3'd0) && (len <= V6_LEN_MAX);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/aitc_scan.sv -----
// Front end: takes one character per cycle while the queue has room, tracks groups, emits a class at end of text.
`default_nettype none
module aitc_scan
    import aitc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_character,
    input  wire logic       i_end_of_text,
    input  wire logic       i_full,
    output t_req            o_push
);

    logic [2:0] r_dot_count,   n_dot_count;
    logic [3:0] r_colon_count, n_colon_count;
    logic [2:0] r_group_length, n_group_length;
    logic [9:0] r_group_value, n_group_value;
    logic       r_group_lz,    n_group_lz;
    logic       r_v4_failed,   n_v4_failed;
    logic       r_v6_failed,   n_v6_failed;

    logic        accept;
    logic        ch_dec;
    t_addr_class cls;

    assign accept = i_valid && !i_full;
    assign ch_dec = is_dec(i_character);

    always_comb begin
        n_dot_count    = r_dot_count;
        n_colon_count  = r_colon_count;
        n_group_length = r_group_length;
        n_group_value  = r_group_value;
        n_group_lz     = r_group_lz;
        n_v4_failed    = r_v4_failed;
        n_v6_failed    = r_v6_failed;
        if (i_character == CH_DOT) begin
            n_v6_failed = 1'b1;
            if (!v4_group_ok(r_group_length, r_group_value, r_group_lz)) begin
                n_v4_failed = 1'b1;
            end
            if (r_dot_count < DOT_MAX) begin
                n_dot_count = r_dot_count + 3'd1;
            end
            n_group_length = '0;
            n_group_value  = '0;
            n_group_lz     = 1'b0;
        end else if (i_character == CH_COLON) begin
            n_v4_failed = 1'b1;
            if (!v6_group_ok(r_group_length)) begin
                n_v6_failed = 1'b1;
            end
            if (r_colon_count < COLON_MAX) begin
                n_colon_count = r_colon_count + 4'd1;
            end
            n_group_length = '0;
            n_group_value  = '0;
            n_group_lz     = 1'b0;
        end else begin
            if (!ch_dec) begin
                n_v4_failed = 1'b1;
            end
            if (!is_hex(i_character)) begin
                n_v6_failed = 1'b1;
            end
            if ((r_group_length == 3'd0) && (i_character == CH_ZERO)) begin
                n_group_lz = 1'b1;
            end
            // decimal digit value is the low nibble of its code
            if (ch_dec && (r_group_length < V4_LEN_MAX)) begin
                n_group_value = 10'((14'(r_group_value) * 14'd10) + 14'(i_character[3:0]));
            end
            if (r_group_length < LEN_MAX) begin
                n_group_length = r_group_length + 3'd1;
            end
        end
    end

    always_comb begin
        cls = ACLS_NEITHER;
        if (!n_v4_failed && (n_dot_count == V4_DOTS) && (n_colon_count == 4'd0)
            && v4_group_ok(n_group_length, n_group_value, n_group_lz)) begin
            cls = ACLS_IPV4;
        end else if (!n_v6_failed && (n_colon_count == V6_COLONS) && (n_dot_count == 3'd0)
            && v6_group_ok(n_group_length)) begin
            cls = ACLS_IPV6;
        end
    end

    assign o_push = '{valid: accept && i_end_of_text, address_class: cls};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_end_of_text)) begin
            r_dot_count    <= '0;
            r_colon_count  <= '0;
            r_group_length <= '0;
            r_group_value  <= '0;
            r_group_lz     <= 1'b0;
            r_v4_failed    <= 1'b0;
            r_v6_failed    <= 1'b0;
        end else if (accept) begin
            r_dot_count    <= n_dot_count;
            r_colon_count  <= n_colon_count;
            r_group_length <= n_group_length;
            r_group_value  <= n_group_value;
            r_group_lz     <= n_group_lz;
            r_v4_failed    <= n_v4_failed;
            r_v6_failed    <= n_v6_failed;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |=> (r_dot_count == 3'd0) && (r_colon_count == 4'd0)
                         && (r_group_length == 3'd0) && !r_v4_failed && !r_v6_failed)
        else $error("scanner state not cleared after end of text");
    a_group_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_group_value <= 10'd999)
        else $error("group value out of range");
`endif

endmodule
`default_nettype wire

// ----- rtl/aitc_queue.sv -----
// Short request queue between the scanner and the output stage.
`default_nettype none
module aitc_queue
    import aitc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_req i_push,
    input  wire logic i_pop,
    output logic      o_full,
    output t_req      o_head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_addr_class   r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && (r_count != '0);

    assign o_head = '{valid: (r_count != '0), address_class: r_mem[r_rd_ptr]};

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.address_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.valid && o_full))
        else $error("request pushed into full queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count exceeds depth");
`endif

endmodule
`default_nettype wire

// ----- rtl/aitc_out.sv -----
// Back end: output register that presents one class per request and holds it while stalled.
`default_nettype none
module aitc_out
    import aitc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_req       i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_address_class
);

    logic        r_valid;
    t_addr_class r_class;

    // load a new request whenever the register is empty or being taken
    assign o_pop = i_head.valid && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_class <= i_head.address_class;
        end
    end

    assign o_valid         = r_valid;
    assign o_address_class = r_class;

endmodule
`default_nettype wire

// ----- rtl/ip_address_text_classifier_unit.sv -----
// Top level of the IPv4 / IPv6 address text classifier.
`default_nettype none
// Takes an address text one character per cycle and returns one class per text
// (0 neither, 1 IPv4, 2 IPv6) after its end-of-text character. The scanner accepts
// a character every cycle as long as the request queue has room; the only stall
// toward the sender comes from a full queue, which fills only while the output
// side holds results back. A class is registered in the request queue and then in
// the output register before it appears on the output. QUEUE_DEPTH (2 or more)
// sets how many finished classes may wait before the input stalls.
module ip_address_text_classifier_unit
    import aitc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_character,
    input  wire logic       i_end_of_text,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_address_class
);

    t_req push;
    t_req head;
    logic full;
    logic pop;

    assign o_stall = full;

    aitc_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_character   (i_character),
        .i_end_of_text (i_end_of_text),
        .i_full        (full),
        .o_push        (push)
    );

    aitc_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    aitc_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_address_class (o_address_class)
    );

endmodule
`default_nettype wire
